// ----- sv/mhsa_pkg.sv -----
// shared types, constants and hash table builder for the minhash signature block
`default_nettype none
package mhsa_pkg;

	localparam int unsigned NumHashes  = 20;
	localparam int unsigned NumColumns = 8;
	localparam int unsigned MaxRows    = 16;
	localparam int unsigned Buckets    = 100;
	localparam int unsigned Prime      = 101;

	localparam int unsigned KindW = 2;
	localparam int unsigned RowW  = 4;
	localparam int unsigned BitsW = 8;
	localparam int unsigned HashW = 5;
	localparam int unsigned ColW  = 3;
	localparam int unsigned MinW  = 14;

	localparam int unsigned RowCount = 1 << RowW;

	localparam logic [MinW-1:0] EmptyMin = MinW'(10000);

	typedef enum logic [KindW-1:0] {
		KIND_ADD   = 2'd0,
		KIND_READ  = 2'd1,
		KIND_CLEAR = 2'd2
	} kind_t;

	typedef struct packed {
		logic             add;
		logic             clear;
		logic [RowW-1:0]  row;
		logic [BitsW-1:0] bits;
	} lane_ctl_t;

	typedef logic [RowCount-1:0][MinW-1:0] hash_tab_t;

	// hash value of every row key for hash function h
	function automatic hash_tab_t hash_row_table(int unsigned h);
		int unsigned x;
		int unsigned y;
		int unsigned t;
		hash_tab_t   tab;
		x = 0;
		y = 1;
		for (int unsigned i = 0; i <= h; i++) begin
			x = (x + y) % Prime;
			y = (x + y) % Prime;
		end
		for (int unsigned r = 0; r < RowCount; r++) begin
			t = (x * r + y) % Prime;
			tab[r] = MinW'(t % Buckets);
		end
		return tab;
	endfunction

endpackage
`default_nettype wire

// ----- sv/mhsa_lane.sv -----
// one hash lane: row hash lookup and the per-column minimum cells
`default_nettype none
module mhsa_lane import mhsa_pkg::*; #(
	parameter int unsigned LANE        = 0,
	parameter int unsigned NUM_COLUMNS = NumColumns
) (
	input  wire logic                                clk,
	input  wire logic                                arst_n,
	input  wire lane_ctl_t                           ctl,
	output logic [NUM_COLUMNS-1:0][MinW-1:0]         lane_min
);

	localparam hash_tab_t HashTab = hash_row_table(LANE);

	logic [MinW-1:0]                  hv;
	logic [NUM_COLUMNS-1:0]           valid_q;
	logic [NUM_COLUMNS-1:0][MinW-1:0] min_q;
	logic [NUM_COLUMNS-1:0]           col_set;
	logic [NUM_COLUMNS-1:0]           lower;

	assign hv = HashTab[ctl.row];

	for (genvar c = 0; c < NUM_COLUMNS; c++) begin : g_col
		if (c < BitsW) begin : g_bit
			assign col_set[c] = ctl.bits[c];
		end else begin : g_nobit
			assign col_set[c] = 1'b0;
		end

		assign lower[c]    = ctl.add && col_set[c] && (!valid_q[c] || hv < min_q[c]);
		assign lane_min[c] = valid_q[c] ? min_q[c] : EmptyMin;

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				valid_q[c] <= 1'b0;
			end else if (ctl.clear) begin
				valid_q[c] <= 1'b0;
			end else if (lower[c]) begin
				valid_q[c] <= 1'b1;
			end
		end

		always_ff @(posedge clk) begin
			if (lower[c]) begin
				min_q[c] <= hv;
			end
		end
	end

	a_clear_empties: assert property (@(posedge clk) disable iff (!arst_n)
		ctl.clear |=> valid_q == '0)
		else $error("lane cells not empty after clear");

endmodule
`default_nettype wire

// ----- sv/mhsa_merge.sv -----
// read merge: picks one lane minimum and registers the result
`default_nettype none
module mhsa_merge import mhsa_pkg::*; #(
	parameter int unsigned NUM_HASHES  = NumHashes,
	parameter int unsigned NUM_COLUMNS = NumColumns
) (
	input  wire logic                                          clk,
	input  wire logic                                          arst_n,
	input  wire logic                                          rd,
	input  wire logic [HashW-1:0]                              hash_index,
	input  wire logic [ColW-1:0]                               column_index,
	input  wire logic [NUM_HASHES-1:0][NUM_COLUMNS-1:0][MinW-1:0] all_min,
	output logic                                               done,
	output logic [MinW-1:0]                                    min_value
);

	localparam int unsigned HW = (NUM_HASHES > 1) ? $clog2(NUM_HASHES) : 1;
	localparam int unsigned CW = (NUM_COLUMNS > 1) ? $clog2(NUM_COLUMNS) : 1;

	logic [HW-1:0]   hsel;
	logic [CW-1:0]   csel;
	logic            in_range;
	logic [MinW-1:0] pick;
	logic            done_q;
	logic [MinW-1:0] min_value_q;

	assign hsel     = HW'(hash_index);
	assign csel     = CW'(column_index);
	assign in_range = (32'(hash_index) < NUM_HASHES) && (32'(column_index) < NUM_COLUMNS);
	assign pick     = in_range ? all_min[hsel][csel] : EmptyMin;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			done_q <= 1'b0;
		end else begin
			done_q <= rd;
		end
	end

	always_ff @(posedge clk) begin
		if (rd) begin
			min_value_q <= pick;
		end
	end

	assign done      = done_q;
	assign min_value = min_value_q;

	a_read_strobes: assert property (@(posedge clk) disable iff (!arst_n)
		rd |=> done)
		else $error("read request gave no result");

	a_no_spurious: assert property (@(posedge clk) disable iff (!arst_n)
		!rd |=> !done)
		else $error("result without read request");

	a_value_range: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> (min_value < MinW'(Buckets) || min_value == EmptyMin))
		else $error("result outside hash range");

endmodule
`default_nettype wire

// ----- sv/minhash_signature_accumulator_top.sv -----
// minhash signature accumulator top level: decode, hash lanes and read merge
// an add lowers the minima of its set columns and a clear empties all minima, at the edge that accepts it
// a read request gives its result on min_value with done in the cycle after acceptance
// busy stays low, so one request is taken every cycle; the receiver cannot stall
// all lanes and their column cells update in parallel in that same cycle
// reset marks every minimum empty (10000) at once, no clearing pass
`default_nettype none
module minhash_signature_accumulator_top import mhsa_pkg::*; #(
	parameter int unsigned NUM_HASHES  = NumHashes,
	parameter int unsigned NUM_COLUMNS = NumColumns
) (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              start,
	output logic                   busy,
	input  wire logic [KindW-1:0]  kind,
	input  wire logic [RowW-1:0]   row_index,
	input  wire logic [BitsW-1:0]  row_bits,
	input  wire logic [HashW-1:0]  hash_index,
	input  wire logic [ColW-1:0]   column_index,
	output logic                   done,
	output logic [MinW-1:0]        min_value
);

	logic                                             accept;
	logic                                             rd;
	lane_ctl_t                                        ctl;
	logic [NUM_HASHES-1:0][NUM_COLUMNS-1:0][MinW-1:0] all_min;

	assign busy   = 1'b0;
	assign accept = start && !busy;

	always_comb begin
		ctl.add   = 1'b0;
		ctl.clear = 1'b0;
		ctl.row   = row_index;
		ctl.bits  = row_bits;
		rd        = 1'b0;
		unique case (kind_t'(kind))
			KIND_ADD: begin
				ctl.add = accept && (32'(row_index) < MaxRows);
			end
			KIND_READ: begin
				rd = accept;
			end
			KIND_CLEAR: begin
				ctl.clear = accept;
			end
			default: begin
			end
		endcase
	end

	for (genvar h = 0; h < NUM_HASHES; h++) begin : g_lane
		mhsa_lane #(
			.LANE        (h),
			.NUM_COLUMNS (NUM_COLUMNS)
		) u_lane (
			.clk      (clk),
			.arst_n   (arst_n),
			.ctl      (ctl),
			.lane_min (all_min[h])
		);
	end

	mhsa_merge #(
		.NUM_HASHES  (NUM_HASHES),
		.NUM_COLUMNS (NUM_COLUMNS)
	) u_merge (
		.clk          (clk),
		.arst_n       (arst_n),
		.rd           (rd),
		.hash_index   (hash_index),
		.column_index (column_index),
		.all_min      (all_min),
		.done         (done),
		.min_value    (min_value)
	);

endmodule
`default_nettype wire
